// ----- sv/cqp_pkg.sv -----
// Shared types and constants for the CoAP request parser.
// Holds parse phase codes, event and error codes, and the result item layout.
// No dependencies.
package cqp_pkg;

	// Upper bound on bytes per packet, applied on top of the length register
	localparam logic [15:0] PACKET_BYTES = 16'd1152;

	// Most result items one input byte can cause
	localparam int MAX_RESULTS = 3;

	// Result queue depth and the fill level up to which a new byte is taken
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CNT_W-1:0] READY_LEVEL = QUEUE_CNT_W'(QUEUE_DEPTH - 2 * MAX_RESULTS);

	// Register indexes of the configuration port
	localparam logic REG_MAX_REQUEST_CODE  = 1'b0;
	localparam logic REG_MAX_PACKET_LENGTH = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0]  MAX_CODE_RESET = 8'd4;
	localparam logic [15:0] MAX_LEN_RESET  = 16'd1152;

	// Parse phases
	localparam logic [3:0] PH_H0       = 4'd0;
	localparam logic [3:0] PH_H1       = 4'd1;
	localparam logic [3:0] PH_H2       = 4'd2;
	localparam logic [3:0] PH_H3       = 4'd3;
	localparam logic [3:0] PH_TOKEN    = 4'd4;
	localparam logic [3:0] PH_OPT      = 4'd5;
	localparam logic [3:0] PH_DEXT1    = 4'd6;
	localparam logic [3:0] PH_DEXT2HI  = 4'd7;
	localparam logic [3:0] PH_DEXT2LO  = 4'd8;
	localparam logic [3:0] PH_LEXT1    = 4'd9;
	localparam logic [3:0] PH_LEXT2HI  = 4'd10;
	localparam logic [3:0] PH_LEXT2LO  = 4'd11;
	localparam logic [3:0] PH_VALUE    = 4'd12;
	localparam logic [3:0] PH_PAYLOAD  = 4'd13;
	localparam logic [3:0] PH_DRAIN    = 4'd14;

	// Event kinds
	localparam logic [2:0] EV_NONE        = 3'd0;
	localparam logic [2:0] EV_TOKEN_BYTE  = 3'd1;
	localparam logic [2:0] EV_HEADER_DONE = 3'd2;
	localparam logic [2:0] EV_OPTION_BYTE = 3'd3;
	localparam logic [2:0] EV_OPTION_DONE = 3'd4;
	localparam logic [2:0] EV_PAYLOAD     = 3'd5;
	localparam logic [2:0] EV_OK          = 3'd6;
	localparam logic [2:0] EV_ERROR       = 3'd7;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_VERSION   = 3'd1;
	localparam logic [2:0] ERR_NOT_REQ   = 3'd2;
	localparam logic [2:0] ERR_DELTA15   = 3'd3;
	localparam logic [2:0] ERR_LENGTH15  = 3'd4;
	localparam logic [2:0] ERR_BLOCK_LEN = 3'd5;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

	// Option nibble escapes and special bytes
	localparam logic [3:0]  NIB_EXT1     = 4'd13;
	localparam logic [3:0]  NIB_EXT2     = 4'd14;
	localparam logic [3:0]  NIB_BAD      = 4'd15;
	localparam logic [7:0]  PAYLOAD_MARK = 8'hFF;
	localparam logic [16:0] EXT1_BIAS    = 17'd13;
	localparam logic [16:0] EXT2_BIAS    = 17'd269;
	localparam logic [15:0] OPT_BLOCK1   = 16'd27;
	localparam logic [15:0] OPT_BLOCK2   = 16'd23;
	localparam logic [1:0]  COAP_VERSION = 2'd1;

	// One result item
	typedef struct packed {
		logic        last;
		logic [2:0]  event_kind;
		logic [2:0]  error_code;
		logic [3:0]  token_length;
		logic [15:0] msg_ident;
		logic [7:0]  message_code;
		logic [1:0]  message_type;
		logic [23:0] option_value;
		logic [16:0] option_length;
		logic [15:0] option_number;
		logic [7:0]  data_byte;
	} cqp_item_t;

	// Result items of one input byte, bound for the queue
	typedef struct packed {
		logic [1:0]                  count;
		cqp_item_t [MAX_RESULTS-1:0] item;
	} cqp_push_t;

	// Configuration register values
	typedef struct packed {
		logic [7:0]  max_request_code;
		logic [15:0] max_packet_length;
	} cqp_cfg_t;

endpackage

// ----- sv/coap_request_parser.sv -----
// Path: an accepted byte enters the input register, then is decoded into the result
// queue, whose head drives the output. Throughput: one byte per cycle while bytes give
// at most one result each and the output is ready; a byte giving two or three results
// holds the output for as many transfers, buffered by an 8-entry queue.
// Reset (arst_n low): parser at packet start, queue empty, max code 4, max len 1152.
module coap_request_parser (
	input  logic          clk,
	input  logic          arst_n,
	// configuration write port
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data,
	// input stream
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,  // [7:0] byte_in
	input  logic          s_axis_tlast,
	// result stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [7:0] data_byte, [23:8] option_number, [40:24] option_length,
	// [64:41] option_value, [66:65] message_type, [74:67] message_code,
	// [90:75] msg_ident, [94:91] token_length, [97:95] error_code, [103:98] zero
	output logic [103:0]  m_axis_tdata,
	output logic [2:0]    m_axis_tuser,  // [2:0] event_kind
	output logic          m_axis_tlast
);

	cqp_pkg::cqp_cfg_t   cfg_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eop_s1;
	cqp_pkg::cqp_push_t  push;
	cqp_pkg::cqp_item_t  head;
	logic [cqp_pkg::QUEUE_CNT_W-1:0] level;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_request_code  <= cqp_pkg::MAX_CODE_RESET;
			cfg_q.max_packet_length <= cqp_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cqp_pkg::REG_MAX_REQUEST_CODE:  cfg_q.max_request_code  <= cfg_data[7:0];
				cqp_pkg::REG_MAX_PACKET_LENGTH: cfg_q.max_packet_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept a byte while the queue has room for this and the in-flight byte
	assign s_axis_tready = (level <= cqp_pkg::READY_LEVEL);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eop_s1  <= s_axis_tlast;
		end
	end

	cqp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (valid_s1),
		.in_byte  (byte_s1),
		.in_eop   (eop_s1),
		.push     (push)
	);

	cqp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (head),
		.count     (level)
	);

	// Pack the head item onto the result stream
	assign m_axis_tdata = {6'd0, head.error_code, head.token_length, head.msg_ident,
		head.message_code, head.message_type, head.option_value, head.option_length,
		head.option_number, head.data_byte};
	assign m_axis_tuser = head.event_kind;
	assign m_axis_tlast = head.last;

endmodule

// ----- sv/cqp_parse.sv -----
// Parse state and per-byte decode for the CoAP request parser.
// Takes one registered byte per cycle and produces up to three result items.
// Depends on cqp_pkg.
module cqp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  cqp_pkg::cqp_cfg_t  cfg,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               in_eop,
	output cqp_pkg::cqp_push_t push
);

	logic [3:0]  phase_q, phase_n;
	logic [15:0] byte_count_q, byte_count_n;
	logic [31:0] hdr_q, hdr_n;
	logic [3:0]  token_left_q, token_left_n;
	logic [15:0] opt_acc_q, opt_acc_n;
	logic [16:0] delta_q, delta_n;
	logic [16:0] length_q, length_n;
	logic [16:0] value_left_q, value_left_n;
	logic [23:0] int_acc_q, int_acc_n;
	logic [2:0]  err_q, err_n;

	logic [15:0] limit;
	logic [16:0] next_count;
	logic        after_delta;
	logic        finish_hdr;
	logic [17:0] num_sum;
	logic [15:0] num_sat;
	logic [1:0]  n_emit;
	cqp_pkg::cqp_item_t [cqp_pkg::MAX_RESULTS-1:0] items;

	// Build an item without header fields
	function automatic cqp_pkg::cqp_item_t mk_item(input logic [2:0] kind,
			input logic [7:0] data, input logic [15:0] num, input logic [16:0] len,
			input logic [23:0] val, input logic [2:0] err);
		cqp_pkg::cqp_item_t it;
		it = '0;
		it.event_kind    = kind;
		it.data_byte     = data;
		it.option_number = num;
		it.option_length = len;
		it.option_value  = val;
		it.error_code    = err;
		return it;
	endfunction

	assign limit = (cfg.max_packet_length > cqp_pkg::PACKET_BYTES) ?
		cqp_pkg::PACKET_BYTES : cfg.max_packet_length;

	// Decode one byte
	always_comb begin
		phase_n      = phase_q;
		byte_count_n = byte_count_q;
		hdr_n        = hdr_q;
		token_left_n = token_left_q;
		opt_acc_n    = opt_acc_q;
		delta_n      = delta_q;
		length_n     = length_q;
		value_left_n = value_left_q;
		int_acc_n    = int_acc_q;
		err_n        = err_q;
		next_count   = {1'b0, byte_count_q} + 17'd1;
		after_delta  = 1'b0;
		finish_hdr   = 1'b0;
		num_sum      = '0;
		num_sat      = '0;
		n_emit       = '0;
		items        = '0;

		if (in_valid && phase_q != cqp_pkg::PH_DRAIN) begin
			byte_count_n = next_count[16] ? 16'hFFFF : next_count[15:0];
			if (next_count > {1'b0, limit}) begin
				if (err_n == cqp_pkg::ERR_NONE) err_n = cqp_pkg::ERR_OVERFLOW;
				phase_n = cqp_pkg::PH_DRAIN;
			end else begin
				unique case (phase_q)
					cqp_pkg::PH_H0: begin
						hdr_n[31:24] = in_byte;
						phase_n = cqp_pkg::PH_H1;
					end
					cqp_pkg::PH_H1: begin
						hdr_n[23:16] = in_byte;
						phase_n = cqp_pkg::PH_H2;
					end
					cqp_pkg::PH_H2: begin
						hdr_n[15:8] = in_byte;
						phase_n = cqp_pkg::PH_H3;
					end
					cqp_pkg::PH_H3: begin
						hdr_n[7:0] = in_byte;
						if (hdr_n[31:30] != cqp_pkg::COAP_VERSION) begin
							err_n = cqp_pkg::ERR_VERSION;
							phase_n = cqp_pkg::PH_DRAIN;
						end else if (hdr_n[23:16] > cfg.max_request_code) begin
							err_n = cqp_pkg::ERR_NOT_REQ;
							phase_n = cqp_pkg::PH_DRAIN;
						end else begin
							items[n_emit] = mk_item(cqp_pkg::EV_HEADER_DONE, '0, '0, '0, '0,
								cqp_pkg::ERR_NONE);
							n_emit = n_emit + 2'd1;
							token_left_n = hdr_n[27:24];
							phase_n = (hdr_n[27:24] != 4'd0) ? cqp_pkg::PH_TOKEN :
								cqp_pkg::PH_OPT;
						end
					end
					cqp_pkg::PH_TOKEN: begin
						items[n_emit] = mk_item(cqp_pkg::EV_TOKEN_BYTE, in_byte, '0, '0, '0,
							cqp_pkg::ERR_NONE);
						n_emit = n_emit + 2'd1;
						token_left_n = token_left_q - 4'd1;
						if (token_left_n == 4'd0) phase_n = cqp_pkg::PH_OPT;
					end
					cqp_pkg::PH_OPT: begin
						if (in_byte == cqp_pkg::PAYLOAD_MARK) begin
							phase_n = cqp_pkg::PH_PAYLOAD;
						end else if (in_byte[7:4] == cqp_pkg::NIB_BAD) begin
							err_n = cqp_pkg::ERR_DELTA15;
							phase_n = cqp_pkg::PH_DRAIN;
						end else if (in_byte[3:0] == cqp_pkg::NIB_BAD) begin
							err_n = cqp_pkg::ERR_LENGTH15;
							phase_n = cqp_pkg::PH_DRAIN;
						end else begin
							delta_n  = {13'd0, in_byte[7:4]};
							length_n = {13'd0, in_byte[3:0]};
							if (in_byte[7:4] == cqp_pkg::NIB_EXT1) phase_n = cqp_pkg::PH_DEXT1;
							else if (in_byte[7:4] == cqp_pkg::NIB_EXT2)
								phase_n = cqp_pkg::PH_DEXT2HI;
							else after_delta = 1'b1;
						end
					end
					cqp_pkg::PH_DEXT1: begin
						delta_n = cqp_pkg::EXT1_BIAS + {9'd0, in_byte};
						after_delta = 1'b1;
					end
					cqp_pkg::PH_DEXT2HI: begin
						delta_n = {1'b0, in_byte, 8'd0};
						phase_n = cqp_pkg::PH_DEXT2LO;
					end
					cqp_pkg::PH_DEXT2LO: begin
						delta_n = delta_q + {9'd0, in_byte} + cqp_pkg::EXT2_BIAS;
						after_delta = 1'b1;
					end
					cqp_pkg::PH_LEXT1: begin
						length_n = cqp_pkg::EXT1_BIAS + {9'd0, in_byte};
						finish_hdr = 1'b1;
					end
					cqp_pkg::PH_LEXT2HI: begin
						length_n = {1'b0, in_byte, 8'd0};
						phase_n = cqp_pkg::PH_LEXT2LO;
					end
					cqp_pkg::PH_LEXT2LO: begin
						length_n = length_q + {9'd0, in_byte} + cqp_pkg::EXT2_BIAS;
						finish_hdr = 1'b1;
					end
					cqp_pkg::PH_VALUE: begin
						items[n_emit] = mk_item(cqp_pkg::EV_OPTION_BYTE, in_byte, opt_acc_q,
							length_q, '0, cqp_pkg::ERR_NONE);
						n_emit = n_emit + 2'd1;
						int_acc_n = {int_acc_q[15:0], in_byte};
						value_left_n = value_left_q - 17'd1;
						if (value_left_n == 17'd0) begin
							items[n_emit] = mk_item(cqp_pkg::EV_OPTION_DONE, '0, opt_acc_q,
								length_q, int_acc_n, cqp_pkg::ERR_NONE);
							n_emit = n_emit + 2'd1;
							phase_n = cqp_pkg::PH_OPT;
						end
					end
					cqp_pkg::PH_PAYLOAD: begin
						items[n_emit] = mk_item(cqp_pkg::EV_PAYLOAD, in_byte, '0, '0, '0,
							cqp_pkg::ERR_NONE);
						n_emit = n_emit + 2'd1;
					end
					default: begin
						phase_n = cqp_pkg::PH_DRAIN;
					end
				endcase

				// Length extension follows the delta, if any
				if (after_delta) begin
					if (length_n == {13'd0, cqp_pkg::NIB_EXT1}) phase_n = cqp_pkg::PH_LEXT1;
					else if (length_n == {13'd0, cqp_pkg::NIB_EXT2})
						phase_n = cqp_pkg::PH_LEXT2HI;
					else finish_hdr = 1'b1;
				end

				// Option header complete: advance the option number, check block option lengths, then emit or start the value
				if (finish_hdr) begin
					num_sum = {2'b00, opt_acc_q} + {1'b0, delta_n};
					num_sat = (num_sum > 18'h0FFFF) ? 16'hFFFF : num_sum[15:0];
					opt_acc_n = num_sat;
					if ((num_sat == cqp_pkg::OPT_BLOCK2 || num_sat == cqp_pkg::OPT_BLOCK1) &&
							(length_n < 17'd1 || length_n > 17'd3)) begin
						err_n = cqp_pkg::ERR_BLOCK_LEN;
						phase_n = cqp_pkg::PH_DRAIN;
					end else begin
						int_acc_n = '0;
						if (length_n == 17'd0) begin
							items[n_emit] = mk_item(cqp_pkg::EV_OPTION_DONE, '0, num_sat, '0,
								'0, cqp_pkg::ERR_NONE);
							n_emit = n_emit + 2'd1;
							phase_n = cqp_pkg::PH_OPT;
						end else begin
							value_left_n = length_n;
							phase_n = cqp_pkg::PH_VALUE;
						end
					end
				end
			end
		end

		// Verdict on the end-marked byte
		if (in_valid && in_eop) begin
			if (err_n == cqp_pkg::ERR_NONE && phase_n != cqp_pkg::PH_OPT &&
					phase_n != cqp_pkg::PH_PAYLOAD)
				err_n = cqp_pkg::ERR_OVERFLOW;
			items[n_emit] = mk_item((err_n != cqp_pkg::ERR_NONE) ? cqp_pkg::EV_ERROR :
				cqp_pkg::EV_OK, '0, '0, '0, '0, err_n);
			items[n_emit].last = 1'b1;
			n_emit = n_emit + 2'd1;
		end

		// Header fields ride on every item
		for (int i = 0; i < cqp_pkg::MAX_RESULTS; i++) begin
			items[i].message_type = hdr_n[29:28];
			items[i].message_code = hdr_n[23:16];
			items[i].msg_ident    = hdr_n[15:0];
			items[i].token_length = hdr_n[27:24];
		end

		// Return to reset state after the verdict
		if (in_valid && in_eop) begin
			phase_n      = cqp_pkg::PH_H0;
			byte_count_n = '0;
			hdr_n        = '0;
			token_left_n = '0;
			opt_acc_n    = '0;
			delta_n      = '0;
			length_n     = '0;
			value_left_n = '0;
			int_acc_n    = '0;
			err_n        = cqp_pkg::ERR_NONE;
		end
	end

	assign push.count = n_emit;
	assign push.item  = items;

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cqp_pkg::PH_H0;
			byte_count_q <= '0;
			hdr_q        <= '0;
			token_left_q <= '0;
			opt_acc_q    <= '0;
			delta_q      <= '0;
			length_q     <= '0;
			value_left_q <= '0;
			int_acc_q    <= '0;
			err_q        <= cqp_pkg::ERR_NONE;
		end else begin
			phase_q      <= phase_n;
			byte_count_q <= byte_count_n;
			hdr_q        <= hdr_n;
			token_left_q <= token_left_n;
			opt_acc_q    <= opt_acc_n;
			delta_q      <= delta_n;
			length_q     <= length_n;
			value_left_q <= value_left_n;
			int_acc_q    <= int_acc_n;
			err_q        <= err_n;
		end
	end

	// A latched error always parks the parser in drain
	a_err_drains: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != cqp_pkg::ERR_NONE |-> phase_q == cqp_pkg::PH_DRAIN)
		else $error("error latched outside drain phase");

	// No byte, no result
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |-> push.count == 2'd0)
		else $error("result produced without a byte");

	// End-marked byte yields a verdict as its last item
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_eop |-> push.count != 2'd0 &&
		push.item[push.count - 2'd1].last)
		else $error("end of packet without verdict");

endmodule

// ----- sv/cqp_result_fifo.sv -----
// Result queue for the CoAP request parser.
// Takes up to three items per cycle and hands out one per transfer.
// Depends on cqp_pkg.
module cqp_result_fifo (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cqp_pkg::cqp_push_t                   push,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cqp_pkg::cqp_item_t                   out_item,
	output logic [cqp_pkg::QUEUE_CNT_W-1:0]      count
);

	cqp_pkg::cqp_item_t mem_q [cqp_pkg::QUEUE_DEPTH];
	logic [cqp_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [cqp_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [cqp_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            pop;

	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign count     = count_q;

	// Store pushed items in order
	always_ff @(posedge clk) begin
		for (int i = 0; i < cqp_pkg::MAX_RESULTS; i++) begin
			if (i < int'(push.count))
				mem_q[wr_ptr_q + cqp_pkg::QUEUE_PTR_W'(i)] <= push.item[i];
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cqp_pkg::QUEUE_PTR_W'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + cqp_pkg::QUEUE_CNT_W'(push.count) -
				cqp_pkg::QUEUE_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) + int'(push.count) <= cqp_pkg::QUEUE_DEPTH)
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= cqp_pkg::QUEUE_DEPTH)
		else $error("result queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd0 && !pop |=> $stable(count_q))
		else $error("queue level moved without transfer");

endmodule
